// ----- rtl/pbc_pkg.sv -----
`timescale 1ns / 1ps

package pbc_pkg;

    // Counter and output widths
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int OUT_BITS           = 16;
    localparam int OUT_MAX            = 65535;

    // Queue between the tokenizer and the tally unit
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Token positions on a pileup line (counted from 1)
    localparam int TOKEN_BITS = 3;
    localparam logic [TOKEN_BITS-1:0] TOKEN_REF   = 3'd3;
    localparam logic [TOKEN_BITS-1:0] TOKEN_READS = 3'd5;
    localparam logic [TOKEN_BITS-1:0] TOKEN_MAX   = 3'd7;

    // Base codes; also the tally slot of each letter
    localparam logic [2:0] BASE_NONE  = 3'd0;
    localparam logic [2:0] BASE_A     = 3'd1;
    localparam logic [2:0] BASE_C     = 3'd2;
    localparam logic [2:0] BASE_G     = 3'd3;
    localparam logic [2:0] BASE_T     = 3'd4;
    localparam logic [2:0] SLOT_MATCH = 3'd0;
    localparam int         TALLY_SLOTS = 5;

    // Operation kinds passed through the queue
    localparam logic [1:0] OP_REF  = 2'd1;
    localparam logic [1:0] OP_BUMP = 2'd2;
    localparam logic [1:0] OP_EOL  = 2'd3;

    // Characters
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_VTAB    = 8'd11;
    localparam logic [7:0] CH_FORMFD  = 8'd12;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UC      = 8'h43;
    localparam logic [7:0] CH_UG      = 8'h47;
    localparam logic [7:0] CH_UT      = 8'h54;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LC      = 8'h63;
    localparam logic [7:0] CH_LG      = 8'h67;
    localparam logic [7:0] CH_LT      = 8'h74;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] arg;
    } pbc_op_t;

    typedef struct packed {
        logic    valid;
        pbc_op_t op;
    } pbc_req_t;

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) ||
               (c == CH_FORMFD) || (c == CH_CR);
    endfunction

    function automatic logic [2:0] upper_code(logic [7:0] c);
        logic [2:0] code;
        unique case (c)
            CH_UA:   code = BASE_A;
            CH_UC:   code = BASE_C;
            CH_UG:   code = BASE_G;
            CH_UT:   code = BASE_T;
            default: code = BASE_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [2:0] any_case_code(logic [7:0] c);
        logic [2:0] code;
        unique case (c) inside
            CH_UA, CH_LA: code = BASE_A;
            CH_UC, CH_LC: code = BASE_C;
            CH_UG, CH_LG: code = BASE_G;
            CH_UT, CH_LT: code = BASE_T;
            default:      code = BASE_NONE;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/pbc_front.sv -----
`timescale 1ns / 1ps

module pbc_front
    import pbc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     char_in,
    output pbc_req_t       push
);

    logic [TOKEN_BITS-1:0] idx_reg;
    logic [TOKEN_BITS-1:0] idx_next;
    logic [TOKEN_BITS-1:0] idx_bump;
    logic                  inside_reg;
    logic                  inside_next;
    logic [2:0]            letter;

    assign letter = any_case_code(char_in);

    always_comb
    begin
        idx_next    = idx_reg;
        inside_next = inside_reg;
        idx_bump    = idx_reg;
        push        = '0;
        if (accept)
        begin
            if (char_in == CH_NEWLINE)
            begin
                // end of line: flush the line state, hand the result request on
                idx_next          = '0;
                inside_next       = 1'b0;
                push.valid        = 1'b1;
                push.op.kind      = OP_EOL;
            end
            else if (is_space(char_in))
            begin
                inside_next = 1'b0;
            end
            else
            begin
                if (!inside_reg && idx_reg != TOKEN_MAX)
                    idx_bump = idx_reg + TOKEN_BITS'(1);
                idx_next    = idx_bump;
                inside_next = 1'b1;
                if (!inside_reg && idx_bump == TOKEN_REF)
                begin
                    push.valid   = 1'b1;
                    push.op.kind = OP_REF;
                    push.op.arg  = upper_code(char_in);
                end
                else if (idx_bump == TOKEN_READS)
                begin
                    if (char_in == CH_DOT || char_in == CH_COMMA)
                    begin
                        push.valid   = 1'b1;
                        push.op.kind = OP_BUMP;
                        push.op.arg  = SLOT_MATCH;
                    end
                    else if (letter != BASE_NONE)
                    begin
                        push.valid   = 1'b1;
                        push.op.kind = OP_BUMP;
                        push.op.arg  = letter;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            inside_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            inside_reg <= inside_next;
        end
    end

endmodule

// ----- rtl/pbc_queue.sv -----
`timescale 1ns / 1ps

module pbc_queue
    import pbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pbc_req_t push,
    output logic     ready,
    output pbc_req_t head,
    input  logic     pop
);

    pbc_op_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg;
    logic [QPTR_BITS-1:0]  wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg;
    logic [QPTR_BITS-1:0]  rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg;
    logic [QCNT_BITS-1:0]  count_next;
    logic                  do_push;
    logic                  do_pop;

    assign ready      = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.op    = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && ready;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_BITS'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    // the tokenizer only produces work for bytes it was allowed to take
    assert property (@(posedge clk) disable iff (!rst_n) push.valid |-> ready)
        else $error("queue written while full");

    // occupancy tracks the pointers
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_BITS'(QUEUE_DEPTH)) ||
        (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

// ----- rtl/pbc_back.sv -----
`timescale 1ns / 1ps

module pbc_back
    import pbc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pbc_req_t              head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [4*OUT_BITS-1:0] m_tdata,
    output logic                  m_tuser
);

    localparam int WIDE_BITS = COUNT_BITS + OUT_BITS;

    logic [COUNT_BITS-1:0] tally_reg  [TALLY_SLOTS];
    logic [COUNT_BITS-1:0] tally_next [TALLY_SLOTS];
    logic [2:0]            ref_reg;
    logic [2:0]            ref_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [4*OUT_BITS-1:0] out_data_reg;
    logic                  out_known_reg;
    logic [4*OUT_BITS-1:0] result;
    logic                  ref_known;
    logic                  out_free;
    logic                  take_eol;
    logic [COUNT_BITS-1:0] sel [4];
    logic [WIDE_BITS-1:0]  wide [4];

    assign out_free  = !out_valid_reg || m_tready;
    assign pop       = head.valid && (head.op.kind != OP_EOL || out_free);
    assign take_eol  = pop && head.op.kind == OP_EOL;
    assign ref_known = (ref_reg >= BASE_A) && (ref_reg <= BASE_T);

    // reference slot reports matches; an unknown reference gives zero; clip each count to the output width
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sel[k]  = (ref_reg == 3'(k + 1)) ? tally_reg[SLOT_MATCH] : tally_reg[k + 1];
            wide[k] = {{OUT_BITS{1'b0}}, sel[k]};
            result[k*OUT_BITS +: OUT_BITS] =
                !ref_known ? '0
              : (wide[k] > WIDE_BITS'(OUT_MAX)) ? OUT_BITS'(OUT_MAX)
              : wide[k][OUT_BITS-1:0];
        end
    end

    always_comb
    begin
        ref_next = ref_reg;
        for (int j = 0; j < TALLY_SLOTS; j++)
            tally_next[j] = tally_reg[j];
        if (pop)
        begin
            unique case (head.op.kind)
                OP_REF:
                    ref_next = head.op.arg;
                OP_BUMP:
                    for (int j = 0; j < TALLY_SLOTS; j++)
                        if (head.op.arg == 3'(j) && tally_reg[j] != {COUNT_BITS{1'b1}})
                            tally_next[j] = tally_reg[j] + COUNT_BITS'(1);
                OP_EOL:
                begin
                    ref_next = BASE_NONE;
                    for (int j = 0; j < TALLY_SLOTS; j++)
                        tally_next[j] = '0;
                end
                default:
                    ref_next = ref_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take_eol)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg       <= BASE_NONE;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < TALLY_SLOTS; j++)
                tally_reg[j] <= '0;
        end
        else
        begin
            ref_reg       <= ref_next;
            out_valid_reg <= out_valid_next;
            for (int j = 0; j < TALLY_SLOTS; j++)
                tally_reg[j] <= tally_next[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_eol)
        begin
            out_data_reg  <= result;
            out_known_reg <= ref_known;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_known_reg;

`ifndef SYNTHESIS
    // an unknown reference never leaks counts
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("counts reported for unknown reference");

    // a finished line leaves clean tallies behind
    assert property (@(posedge clk) disable iff (!rst_n)
        take_eol |=> (ref_reg == BASE_NONE && tally_reg[SLOT_MATCH] == '0))
        else $error("line state not cleared after newline");
`endif

endmodule

// ----- rtl/pileup_base_counter.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake           Payload
// s_axis    in   s_tvalid/s_tready   s_tdata[7:0] = char_in
// m_axis    out  m_tvalid/m_tready   m_tdata = count_a, count_c, count_g, count_t;
//                                    m_tuser = ref_valid
//
// Takes one byte per clock. A byte is accepted whenever the four-entry op queue
// has room; the tally unit retires one queued op per clock unless a newline waits
// on an occupied output register, and only then does the queue fill.
// A newline is queued, then its result is loaded into the output register and
// raised on m_tvalid, behind any ops queued ahead and any result still waiting.
// Reset clears the tokenizer, queue, tallies and the output valid flag.
// Output stalls hold the result register; input bytes keep flowing until the
// queue fills behind the stalled newline.

module pileup_base_counter
    import pbc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // byte stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] char_in
    // per-line counts out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [4*OUT_BITS-1:0] m_tdata,   // [15:0] count_a, [31:16] count_c,
                                             // [47:32] count_g, [63:48] count_t
    output logic                  m_tuser    // [0] ref_valid
);

    pbc_req_t push;
    pbc_req_t head;
    logic     q_ready;
    logic     pop;
    logic     accept;

    // take a byte only when the queue can absorb whatever op it produces
    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;

    // tokenizer: tracks token position, turns bytes into tally ops
    pbc_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .char_in (s_tdata),
        .push    (push)
    );

    // decouple tokenizer from the tally unit and the output stall
    pbc_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .ready (q_ready),
        .head  (head),
        .pop   (pop)
    );

    // tally unit: saturating counters, reference hold, result register
    pbc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
